@@ rtl/tsw_pkg.sv @@
// shared types, codes and constants of the tile map scroll walker
package tsw_pkg;

   localparam int DEFAULT_MAP_CELLS = 4096;
   localparam logic [7:0] BLANK_TILE = 8'd32;
   // dividend width of the shared divider: clamped offsets stay below 2^18
   localparam int DIV_WIDTH = 18;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_SCROLL = 2'd1,
      ACT_FRAME  = 2'd2,
      ACT_STEP   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_TILE_WIDTH  = 3'd0,
      REG_TILE_HEIGHT = 3'd1,
      REG_MAP_WIDTH   = 3'd2,
      REG_MAP_HEIGHT  = 3'd3,
      REG_VIEW_WIDTH  = 3'd4,
      REG_VIEW_HEIGHT = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      DIV_OFF_X = 2'd0,
      DIV_OFF_Y = 2'd1,
      DIV_WIN_X = 2'd2,
      DIV_WIN_Y = 2'd3
   } div_sel_type;

   // saturated configuration as the datapath uses it
   typedef struct packed {
      logic [6:0]  tile_w;
      logic [6:0]  tile_h;
      logic [12:0] map_w;
      logic [12:0] map_h;
      logic [12:0] view_w;
      logic [12:0] view_h;
   } cfg_type;

   typedef struct packed {
      logic        clear_wr;
      logic        cell_wr;
      logic        scroll_set;
      logic        extent_load;
      logic        clamp;
      logic        div_start;
      logic        div_store;
      div_sel_type div_sel;
      logic        frame_open;
      logic        step_load;
      logic        step_mul;
      logic        step_addr;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic frame_active;
      logic div_done;
   } status_type;

endpackage

@@ rtl/tsw_ram.sv @@
// generic single write port ram with registered read
module tsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tsw_csr.sv @@
// configuration registers with apb-style access and saturated outputs
module tsw_csr import tsw_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   logic [6:0]    tile_w_ff, tile_w_in, tile_h_ff, tile_h_in;
   logic [12:0]   map_w_ff, map_w_in, map_h_ff, map_h_in;
   logic [12:0]   view_w_ff, view_w_in, view_h_ff, view_h_in;
   logic          wr_en;
   reg_index_type reg_idx;

   function automatic logic [6:0] sat_tile(logic [6:0] v);
      return (v == 7'd0) ? 7'd1 : ((v > 7'd64) ? 7'd64 : v);
   endfunction

   function automatic logic [12:0] sat_extent(logic [12:0] v);
      return (v == 13'd0) ? 13'd1 : ((v > 13'd4096) ? 13'd4096 : v);
   endfunction

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign pready  = 1'b1;

   always_comb begin
      tile_w_in = tile_w_ff;
      tile_h_in = tile_h_ff;
      map_w_in  = map_w_ff;
      map_h_in  = map_h_ff;
      view_w_in = view_w_ff;
      view_h_in = view_h_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TILE_WIDTH:  tile_w_in = pwdata[6:0];
            REG_TILE_HEIGHT: tile_h_in = pwdata[6:0];
            REG_MAP_WIDTH:   map_w_in  = pwdata[12:0];
            REG_MAP_HEIGHT:  map_h_in  = pwdata[12:0];
            REG_VIEW_WIDTH:  view_w_in = pwdata[12:0];
            REG_VIEW_HEIGHT: view_h_in = pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TILE_WIDTH:  prdata = CSR_DATA_WIDTH'(tile_w_ff);
         REG_TILE_HEIGHT: prdata = CSR_DATA_WIDTH'(tile_h_ff);
         REG_MAP_WIDTH:   prdata = CSR_DATA_WIDTH'(map_w_ff);
         REG_MAP_HEIGHT:  prdata = CSR_DATA_WIDTH'(map_h_ff);
         REG_VIEW_WIDTH:  prdata = CSR_DATA_WIDTH'(view_w_ff);
         REG_VIEW_HEIGHT: prdata = CSR_DATA_WIDTH'(view_h_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_w_ff <= 7'd8;
         tile_h_ff <= 7'd8;
         map_w_ff  <= 13'd64;
         map_h_ff  <= 13'd64;
         view_w_ff <= 13'd320;
         view_h_ff <= 13'd240;
      end else begin
         tile_w_ff <= tile_w_in;
         tile_h_ff <= tile_h_in;
         map_w_ff  <= map_w_in;
         map_h_ff  <= map_h_in;
         view_w_ff <= view_w_in;
         view_h_ff <= view_h_in;
      end
   end

   assign cfg.tile_w = sat_tile(tile_w_ff);
   assign cfg.tile_h = sat_tile(tile_h_ff);
   assign cfg.map_w  = sat_extent(map_w_ff);
   assign cfg.map_h  = sat_extent(map_h_ff);
   assign cfg.view_w = sat_extent(view_w_ff);
   assign cfg.view_h = sat_extent(view_h_ff);

endmodule

@@ rtl/tsw_div.sv @@
// restoring divider, one quotient bit per cycle
module tsw_div import tsw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_WIDTH-1:0] dividend,
   input  logic [6:0]           divisor,
   output logic                 done,
   output logic [DIV_WIDTH-1:0] quotient,
   output logic [6:0]           remainder
);

   localparam int CountWidth = $clog2(DIV_WIDTH + 1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [DIV_WIDTH-1:0]  quo_ff, quo_in;
   logic [6:0]            rem_ff, rem_in;
   logic [7:0]            shifted;
   logic [7:0]            diff;

   assign shifted = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         count_in = CountWidth'(DIV_WIDTH);
         quo_in   = dividend;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - CountWidth'(1);
         if (shifted >= {1'b0, divisor}) begin
            rem_in = diff[6:0];
            quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[6:0];
            quo_in = {quo_ff[DIV_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = (count_ff == '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/tsw_dp.sv @@
// datapath: map store, scroll and frame state, window walk and result register
module tsw_dp import tsw_pkg::*; #(
   parameter int MAP_CELLS = DEFAULT_MAP_CELLS
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  cfg_type            cfg,
   input  logic [11:0]        cell_index,
   input  logic [7:0]         cell_value,
   input  logic signed [19:0] scroll_x,
   input  logic signed [19:0] scroll_y,
   output logic [7:0]         tile_number,
   output logic signed [13:0] screen_x,
   output logic signed [13:0] screen_y,
   output logic               draw,
   output logic               last
);

   localparam int AddrWidth = $clog2(MAP_CELLS);
   localparam logic [24:0] CellLimit = 25'(MAP_CELLS);
   localparam logic [AddrWidth-1:0] ClearLast = AddrWidth'(MAP_CELLS - 1);

   // frame state
   logic signed [19:0] req_x_ff, req_x_in, req_y_ff, req_y_in;
   logic [19:0]        ext_x_ff, ext_y_ff;
   logic [11:0]        tile_col_ff, tile_row_ff;
   logic [5:0]         rem_x_ff, rem_y_ff;
   logic [12:0]        win_cols_ff, win_rows_ff;
   logic [12:0]        cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   logic               frame_active_ff, frame_active_in;
   logic [AddrWidth-1:0] clear_cnt_ff;

   // step pipeline
   logic [13:0] col_ff, row_ff;
   logic [19:0] sx_prod_ff, sy_prod_ff;
   logic [24:0] map_prod_ff;
   logic        inb_ff, last_ff, tile_ok_ff;
   logic [13:0] sx_ff, sy_ff;
   logic [24:0] addr_ff, addr_sum;

   // result register
   logic [7:0]  tile_number_ff;
   logic [13:0] screen_x_ff, screen_y_ff;
   logic        draw_ff, last_out_ff;

   // divider hookup
   logic [DIV_WIDTH-1:0] div_dividend, div_quotient;
   logic [6:0]           div_divisor, div_remainder;
   logic                 div_done;
   logic [13:0]          span_x, span_y;

   // map store
   logic                 ram_wr_en;
   logic [AddrWidth-1:0] ram_wr_addr;
   logic [7:0]           ram_wr_data, ram_rd_data;
   logic [24:0]          cell_wide;
   logic                 cell_ok;
   logic [7:0]           tile_sel;

   function automatic logic signed [19:0] clamp_offset(logic signed [19:0] req,
                                                      logic [19:0] extent,
                                                      logic [12:0] view);
      logic signed [20:0] upper;
      logic signed [20:0] req_w;
      logic signed [20:0] clip;
      upper = $signed({1'b0, extent}) - $signed({8'b0, view});
      req_w = {req[19], req};
      clip  = (req_w > upper) ? upper : req_w;
      // negative upper bound also lands here
      if (clip[20]) begin
         clip = '0;
      end
      return clip[19:0];
   endfunction

   // ---------------- map store and clear sweep ----------------
   assign cell_wide = {13'b0, cell_index};
   assign cell_ok   = cell_wide < CellLimit;
   assign ram_wr_en = cmd.clear_wr || (cmd.cell_wr && cell_ok);
   assign ram_wr_addr = cmd.clear_wr ? clear_cnt_ff : cell_wide[AddrWidth-1:0];
   assign ram_wr_data = cmd.clear_wr ? BLANK_TILE : cell_value;

   tsw_ram #(
      .WIDTH (8),
      .DEPTH (MAP_CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (addr_ff[AddrWidth-1:0]),
      .rd_data (ram_rd_data)
   );

   // ---------------- shared divider ----------------
   assign span_x = {1'b0, cfg.view_w} + 14'(cfg.tile_w) - 14'd1;
   assign span_y = {1'b0, cfg.view_h} + 14'(cfg.tile_h) - 14'd1;

   always_comb begin
      case (cmd.div_sel)
         DIV_OFF_X: begin
            div_dividend = req_x_ff[DIV_WIDTH-1:0];
            div_divisor  = cfg.tile_w;
         end
         DIV_OFF_Y: begin
            div_dividend = req_y_ff[DIV_WIDTH-1:0];
            div_divisor  = cfg.tile_h;
         end
         DIV_WIN_X: begin
            div_dividend = DIV_WIDTH'(span_x);
            div_divisor  = cfg.tile_w;
         end
         DIV_WIN_Y: begin
            div_dividend = DIV_WIDTH'(span_y);
            div_divisor  = cfg.tile_h;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = 7'd1;
         end
      endcase
   end

   tsw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         case (cmd.div_sel)
            DIV_OFF_X: begin
               tile_col_ff <= div_quotient[11:0];
               rem_x_ff    <= div_remainder[5:0];
            end
            DIV_OFF_Y: begin
               tile_row_ff <= div_quotient[11:0];
               rem_y_ff    <= div_remainder[5:0];
            end
            DIV_WIN_X: win_cols_ff <= div_quotient[12:0] + 13'd1;
            DIV_WIN_Y: win_rows_ff <= div_quotient[12:0] + 13'd1;
            default: ;
         endcase
      end
   end

   // ---------------- scroll offset and frame control ----------------
   always_comb begin
      req_x_in = req_x_ff;
      req_y_in = req_y_ff;
      if (cmd.scroll_set) begin
         req_x_in = scroll_x;
         req_y_in = scroll_y;
      end else if (cmd.clamp) begin
         req_x_in = clamp_offset(req_x_ff, ext_x_ff, cfg.view_w);
         req_y_in = clamp_offset(req_y_ff, ext_y_ff, cfg.view_h);
      end
   end

   always_comb begin
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      frame_active_in = frame_active_ff;
      if (cmd.clamp) begin
         cur_col_in = '0;
         cur_row_in = '0;
      end
      if (cmd.frame_open) begin
         frame_active_in = 1'b1;
      end
      if (cmd.out_load) begin
         if (last_ff) begin
            frame_active_in = 1'b0;
         end else if ({1'b0, cur_row_ff} + 14'd1 < {1'b0, win_rows_ff}) begin
            cur_row_in = cur_row_ff + 13'd1;
         end else begin
            // rows run fastest, wrap into the next column
            cur_row_in = '0;
            cur_col_in = cur_col_ff + 13'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_x_ff        <= '0;
         req_y_ff        <= '0;
         frame_active_ff <= 1'b0;
         clear_cnt_ff    <= '0;
      end else begin
         req_x_ff        <= req_x_in;
         req_y_ff        <= req_y_in;
         frame_active_ff <= frame_active_in;
         if (cmd.clear_wr) begin
            clear_cnt_ff <= clear_cnt_ff + AddrWidth'(1);
         end
      end
      cur_col_ff <= cur_col_in;
      cur_row_ff <= cur_row_in;
      if (cmd.extent_load) begin
         ext_x_ff <= cfg.map_w * cfg.tile_w;
         ext_y_ff <= cfg.map_h * cfg.tile_h;
      end
   end

   // ---------------- step pipeline ----------------
   assign addr_sum = map_prod_ff + 25'(col_ff[11:0]);

   always_ff @(posedge clock) begin
      if (cmd.step_load) begin
         col_ff     <= {1'b0, cur_col_ff} + 14'(tile_col_ff);
         row_ff     <= {1'b0, cur_row_ff} + 14'(tile_row_ff);
         sx_prod_ff <= cur_col_ff * cfg.tile_w;
         sy_prod_ff <= cur_row_ff * cfg.tile_h;
      end
      if (cmd.step_mul) begin
         // only used when the row lies inside the map, so 12 bits suffice
         map_prod_ff <= row_ff[11:0] * cfg.map_w;
         inb_ff      <= (col_ff < {1'b0, cfg.map_w}) && (row_ff < {1'b0, cfg.map_h});
         sx_ff       <= sx_prod_ff[13:0] - {8'b0, rem_x_ff};
         sy_ff       <= sy_prod_ff[13:0] - {8'b0, rem_y_ff};
         last_ff     <= ({1'b0, cur_col_ff} + 14'd1 >= {1'b0, win_cols_ff}) &&
                        ({1'b0, cur_row_ff} + 14'd1 >= {1'b0, win_rows_ff});
      end
      if (cmd.step_addr) begin
         addr_ff    <= addr_sum;
         tile_ok_ff <= inb_ff && (addr_sum < CellLimit);
      end
   end

   // ---------------- result register ----------------
   assign tile_sel = tile_ok_ff ? ram_rd_data : BLANK_TILE;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         tile_number_ff <= tile_sel;
         draw_ff        <= (tile_sel != BLANK_TILE);
         screen_x_ff    <= sx_ff;
         screen_y_ff    <= sy_ff;
         last_out_ff    <= last_ff;
      end
   end

   assign tile_number = tile_number_ff;
   assign screen_x    = $signed(screen_x_ff);
   assign screen_y    = $signed(screen_y_ff);
   assign draw        = draw_ff;
   assign last        = last_out_ff;

   assign status.clear_last   = (clear_cnt_ff == ClearLast);
   assign status.frame_active = frame_active_ff;
   assign status.div_done     = div_done;

endmodule

@@ rtl/tsw_ctrl.sv @@
// controller: sequences clear sweep, frame setup and the step pipeline
module tsw_ctrl import tsw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_CLEAR    = 10'b00_0000_0001,
      ST_IDLE     = 10'b00_0000_0010,
      ST_EXTENT   = 10'b00_0000_0100,
      ST_CLAMP    = 10'b00_0000_1000,
      ST_DIV_LOAD = 10'b00_0001_0000,
      ST_DIV_RUN  = 10'b00_0010_0000,
      ST_MUL      = 10'b00_0100_0000,
      ST_ADDR     = 10'b00_1000_0000,
      ST_READ     = 10'b01_0000_0000,
      ST_OUT      = 10'b10_0000_0000
   } state_type;

   state_type   state_ff, state_in;
   div_sel_type div_sel_ff, div_sel_in;
   logic        rsp_valid_ff, rsp_valid_in;
   action_type  action;

   assign action    = action_type'(req_action);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      div_sel_in  = div_sel_ff;
      cmd         = '0;
      cmd.div_sel = div_sel_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (action)
                  ACT_WRITE:  cmd.cell_wr = 1'b1;
                  ACT_SCROLL: cmd.scroll_set = 1'b1;
                  ACT_FRAME:  state_in = ST_EXTENT;
                  ACT_STEP: begin
                     // a step outside a frame is dropped
                     if (status.frame_active) begin
                        cmd.step_load = 1'b1;
                        state_in      = ST_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_EXTENT: begin
            cmd.extent_load = 1'b1;
            state_in        = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp  = 1'b1;
            div_sel_in = DIV_OFF_X;
            state_in   = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (div_sel_ff == DIV_WIN_Y) begin
                  cmd.frame_open = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  div_sel_in = div_sel_type'(div_sel_ff + 2'd1);
                  state_in   = ST_DIV_LOAD;
               end
            end
         end
         ST_MUL: begin
            cmd.step_mul = 1'b1;
            state_in     = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.step_addr = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         div_sel_ff   <= DIV_OFF_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_sel_ff   <= div_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/tilemap_scroll_walker.sv @@
// top level of the scrolling tile map walker
//
//  port group   direction  handshake          carries
//  req_*        in         req_valid/stall    action, cell index/value, scroll x/y
//  rsp_*        out        rsp_valid/stall    tile number, screen x/y, draw, last
//  csr_*        in/out     apb psel/penable   six size registers at 4*i
//
// write map cell and set scroll are taken without stalling the input.
// start frame runs extent multiply, clamp, then four divisions through the
// one shared bit-serial divider.
// a step runs accept, multiply, address add, map read, result load in turn.
// after reset the whole map store is swept to blank with req_stall high;
// csr writes are taken during the sweep.
// a held result stalls only the result load; the next word is still accepted.
module tilemap_scroll_walker import tsw_pkg::*; #(
   parameter int MAP_CELLS = DEFAULT_MAP_CELLS
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_action,
   input  logic [11:0]               req_cell_index,
   input  logic [7:0]                req_cell_value,
   input  logic signed [19:0]        req_scroll_x,
   input  logic signed [19:0]        req_scroll_y,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_tile_number,
   output logic signed [13:0]        rsp_screen_x,
   output logic signed [13:0]        rsp_screen_y,
   output logic                      rsp_draw,
   output logic                      rsp_last,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   tsw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   tsw_dp #(
      .MAP_CELLS (MAP_CELLS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .cfg         (cfg),
      .cell_index  (req_cell_index),
      .cell_value  (req_cell_value),
      .scroll_x    (req_scroll_x),
      .scroll_y    (req_scroll_y),
      .tile_number (rsp_tile_number),
      .screen_x    (rsp_screen_x),
      .screen_y    (rsp_screen_y),
      .draw        (rsp_draw),
      .last        (rsp_last)
   );

endmodule

@@ rtl/tsw_checker.sv @@
// port-level checker for the tile map walker and its bind
module tsw_checker import tsw_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [1:0]                req_action,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [7:0]                rsp_tile_number,
   input logic signed [13:0]        rsp_screen_x,
   input logic signed [13:0]        rsp_screen_y,
   input logic                      rsp_draw,
   input logic                      rsp_last
);

   // the map sweep holds off input words right after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("input not stalled during map sweep");

   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_FRAME |=> req_stall)
      else $error("frame setup did not stall the input");

   a_simple_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_WRITE || req_action == ACT_SCROLL)
      |=> !req_stall)
      else $error("write or scroll word held the input");

   a_draw_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_draw == (rsp_tile_number != BLANK_TILE))
      else $error("draw flag disagrees with tile number");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tile_number) &&
      $stable(rsp_screen_x) && $stable(rsp_screen_y) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind tilemap_scroll_walker tsw_checker u_checker (.*);

@@ bench/tb_tilemap_scroll_walker.sv @@
// self-checking testbench of the tile map scroll walker with its own draw-command predictor
module tb_tilemap_scroll_walker;
   import tsw_pkg::*;

   localparam int MAP_CELLS   = DEFAULT_MAP_CELLS;
   localparam int SETTLE      = 100;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [7:0]  tile_number;
      logic [13:0] screen_x;
      logic [13:0] screen_y;
      logic        draw;
      logic        last;
   } draw_cmd_type;

   logic clock = 1'b0;
   logic reset;

   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_action;
   logic [11:0]               req_cell_index;
   logic [7:0]                req_cell_value;
   logic signed [19:0]        req_scroll_x;
   logic signed [19:0]        req_scroll_y;

   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [7:0]                rsp_tile_number;
   logic signed [13:0]        rsp_screen_x;
   logic signed [13:0]        rsp_screen_y;
   logic                      rsp_draw;
   logic                      rsp_last;

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // predictor state
   logic [7:0]  map_mem [0:MAP_CELLS-1];
   logic [6:0]  tile_w_reg, tile_h_reg;
   logic [12:0] map_w_reg, map_h_reg, view_w_reg, view_h_reg;
   int          scroll_req_x, scroll_req_y;
   int          tile_col0, tile_row0, rem_x, rem_y;
   int          win_cols, win_rows, cur_col, cur_row;
   bit          frame_open;

   draw_cmd_type pending_draws[$];
   int      errors;
   int      items_sent;
   bit      no_idle;

   tilemap_scroll_walker dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_cell_index  (req_cell_index),
      .req_cell_value  (req_cell_value),
      .req_scroll_x    (req_scroll_x),
      .req_scroll_y    (req_scroll_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tile_number (rsp_tile_number),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_draw        (rsp_draw),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clip(input int v, input int lo, input int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int clamp_scroll(input int want, input int tiles, input int tsize,
                                       input int view);
      int upper;
      upper = tiles * tsize - view;
      if (want > upper) want = upper;
      if (want < 0) want = 0;
      return want;
   endfunction

   // advances the predictor by one word; returns 0 when the block ignores it
   function automatic bit walk_model(input action_type act, input logic [11:0] idx,
                                     input logic [7:0] val, input logic signed [19:0] sx,
                                     input logic signed [19:0] sy);
      int tw, th, mw, mh, vw, vh, col, row, addr, px, py;
      logic [31:0] px_bits, py_bits;
      draw_cmd_type cmd;
      tw = clip(tile_w_reg, 1, 64);
      th = clip(tile_h_reg, 1, 64);
      mw = clip(map_w_reg, 1, 4096);
      mh = clip(map_h_reg, 1, 4096);
      case (act)
         ACT_WRITE: begin
            if (idx < MAP_CELLS) map_mem[idx] = val;
            return 1'b1;
         end
         ACT_SCROLL: begin
            scroll_req_x = int'(sx);
            scroll_req_y = int'(sy);
            return 1'b1;
         end
         ACT_FRAME: begin
            vw = clip(view_w_reg, 1, 4096);
            vh = clip(view_h_reg, 1, 4096);
            scroll_req_x = clamp_scroll(scroll_req_x, mw, tw, vw);
            scroll_req_y = clamp_scroll(scroll_req_y, mh, th, vh);
            tile_col0 = scroll_req_x / tw;
            tile_row0 = scroll_req_y / th;
            rem_x = scroll_req_x % tw;
            rem_y = scroll_req_y % th;
            win_cols = (vw + tw - 1) / tw + 1;
            win_rows = (vh + th - 1) / th + 1;
            cur_col = 0;
            cur_row = 0;
            frame_open = 1'b1;
            return 1'b1;
         end
         default: begin
            if (!frame_open) return 1'b0;
            col = cur_col + tile_col0;
            row = cur_row + tile_row0;
            cmd.tile_number = BLANK_TILE;
            // cells past the map edge or past the store read as blank
            if (col < mw && row < mh) begin
               addr = row * mw + col;
               if (addr < MAP_CELLS) cmd.tile_number = map_mem[addr];
            end
            px = cur_col * tw - rem_x;
            py = cur_row * th - rem_y;
            px_bits = px;
            py_bits = py;
            cmd.screen_x = px_bits[13:0];
            cmd.screen_y = py_bits[13:0];
            cmd.draw = (cmd.tile_number != BLANK_TILE);
            cmd.last = (cur_col + 1 >= win_cols) && (cur_row + 1 >= win_rows);
            pending_draws.push_back(cmd);
            if (cmd.last) begin
               frame_open = 1'b0;
            end else if (cur_row + 1 < win_rows) begin
               cur_row++;
            end else begin
               cur_row = 0;
               cur_col++;
            end
            return 1'b1;
         end
      endcase
   endfunction

   task automatic send_word(input action_type act, input logic [11:0] idx,
                            input logic [7:0] val, input logic signed [19:0] sx,
                            input logic signed [19:0] sy);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_cell_index <= idx;
      req_cell_value <= val;
      req_scroll_x   <= sx;
      req_scroll_y   <= sy;
      do @(posedge clock); while (req_stall);
      if (walk_model(act, idx, val, sx, sy)) items_sent++;
   endtask

   task automatic send_write(input logic [11:0] idx, input logic [7:0] val);
      send_word(ACT_WRITE, idx, val, 20'($urandom), 20'($urandom));
   endtask

   task automatic send_scroll(input logic signed [19:0] sx, input logic signed [19:0] sy);
      send_word(ACT_SCROLL, 12'($urandom), 8'($urandom), sx, sy);
   endtask

   task automatic send_frame();
      send_word(ACT_FRAME, 12'($urandom), 8'($urandom), 20'($urandom), 20'($urandom));
   endtask

   task automatic send_step();
      send_word(ACT_STEP, 12'($urandom), 8'($urandom), 20'($urandom), 20'($urandom));
   endtask

   // block idle: every draw word back and a frame start has had time to finish
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] keep, data;
      keep = (idx == REG_TILE_WIDTH || idx == REG_TILE_HEIGHT) ? 32'h7F : 32'h1FFF;
      // junk above the register width must be dropped
      data = ($urandom_range(0, 3) == 0) ? (value | ($urandom & ~keep)) : value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_TILE_WIDTH:  tile_w_reg = data[6:0];
         REG_TILE_HEIGHT: tile_h_reg = data[6:0];
         REG_MAP_WIDTH:   map_w_reg  = data[12:0];
         REG_MAP_HEIGHT:  map_h_reg  = data[12:0];
         REG_VIEW_WIDTH:  view_w_reg = data[12:0];
         REG_VIEW_HEIGHT: view_h_reg = data[12:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic int pick_tile_size();
      if ($urandom_range(0, 19) < 3) return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(65, 127);
      return $urandom_range(1, 64);
   endfunction

   function automatic int pick_map_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 12);
      if (r < 9) return $urandom_range(13, 100);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 4096;
         2: return 8191;
         default: return $urandom_range(0, 8191);
      endcase
   endfunction

   function automatic logic signed [19:0] pick_scroll(input int tiles, input int tsize);
      int v;
      if ($urandom_range(0, 9) < 3) return 20'($urandom);
      v = int'($urandom_range(0, tiles * tsize + 4 * tsize)) - 2 * tsize;
      return 20'(v);
   endfunction

   function automatic logic [11:0] pick_cell();
      int cells;
      cells = clip(map_w_reg, 1, 4096) * clip(map_h_reg, 1, 4096);
      if (cells <= MAP_CELLS && $urandom_range(0, 4) != 0) return 12'($urandom_range(0, cells - 1));
      return 12'($urandom);
   endfunction

   function automatic logic [7:0] pick_tile();
      return ($urandom_range(0, 3) == 0) ? BLANK_TILE : 8'($urandom);
   endfunction

   // views stay within a few tiles so a window is a few dozen cells at most
   task automatic shuffle_sizes(input bit both_axes);
      write_reg(REG_TILE_WIDTH, pick_tile_size());
      write_reg(REG_MAP_WIDTH, pick_map_size());
      write_reg(REG_VIEW_WIDTH, $urandom_range(1, 5 * clip(tile_w_reg, 1, 64)));
      if (both_axes) begin
         write_reg(REG_TILE_HEIGHT, pick_tile_size());
         write_reg(REG_MAP_HEIGHT, pick_map_size());
         write_reg(REG_VIEW_HEIGHT, $urandom_range(1, 5 * clip(tile_h_reg, 1, 64)));
      end
   endtask

   task automatic test_idle_and_small_frame();
      send_step();
      // reset sizes, offset floors at zero
      send_frame();
      send_step();
      send_step();
      wait_drained();
      write_reg(REG_TILE_WIDTH, 8);
      write_reg(REG_TILE_HEIGHT, 8);
      write_reg(REG_MAP_WIDTH, 4);
      write_reg(REG_MAP_HEIGHT, 3);
      write_reg(REG_VIEW_WIDTH, 12);
      write_reg(REG_VIEW_HEIGHT, 8);
      send_write(12'd8, 8'd0);
      send_write(12'd9, 8'hFF);
      send_write(12'd10, 8'd33);
      send_write(12'hFFF, 8'hA5);
      // x clamps to zero, y to the bottom edge; lower row falls off the map
      send_scroll(20'h80000, 20'h7FFFF);
      send_frame();
      repeat (7) send_step();
   endtask

   task automatic test_size_extremes();
      wait_drained();
      write_reg(REG_TILE_WIDTH, 0);
      write_reg(REG_TILE_HEIGHT, 127);
      write_reg(REG_MAP_WIDTH, 8191);
      write_reg(REG_MAP_HEIGHT, 2);
      write_reg(REG_VIEW_WIDTH, 0);
      write_reg(REG_VIEW_HEIGHT, 8191);
      send_write(12'hFFF, 8'd7);
      // second row addresses past the store, upper y bound is negative
      send_scroll(20'h7FFFF, 20'd5);
      send_frame();
      repeat (3) send_step();
      wait_drained();
      // tile and map sizes are read live inside an open frame
      write_reg(REG_TILE_WIDTH, 64);
      write_reg(REG_MAP_WIDTH, 0);
      repeat (2) send_step();
   endtask

   task automatic test_random_frames();
      int goal, total, steps, split, k;
      goal = items_sent + 1000;
      while (items_sent < goal) begin
         wait_drained();
         no_idle = ($urandom_range(0, 3) == 0);
         shuffle_sizes(1'b1);
         repeat ($urandom_range(2, 12)) send_write(pick_cell(), pick_tile());
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 3) != 0) begin
               send_scroll(pick_scroll(clip(map_w_reg, 1, 4096), clip(tile_w_reg, 1, 64)),
                           pick_scroll(clip(map_h_reg, 1, 4096), clip(tile_h_reg, 1, 64)));
            end
            send_frame();
            total = win_cols * win_rows;
            steps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, total)
                                                : total + $urandom_range(0, 1);
            split = ($urandom_range(0, 7) == 0) ? $urandom_range(1, steps) : 0;
            for (k = 0; k < steps; k++) begin
               if (split != 0 && k == split) begin
                  wait_drained();
                  shuffle_sizes(1'b0);
               end
               if ($urandom_range(0, 9) == 0) send_write(pick_cell(), pick_tile());
               send_step();
            end
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= ACT_WRITE;
      req_cell_index <= '0;
      req_cell_value <= '0;
      req_scroll_x   <= '0;
      req_scroll_y   <= '0;
      rsp_stall      <= 1'b0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      foreach (map_mem[i]) map_mem[i] = BLANK_TILE;
      tile_w_reg = 7'd8;
      tile_h_reg = 7'd8;
      map_w_reg = 13'd64;
      map_h_reg = 13'd64;
      view_w_reg = 13'd320;
      view_h_reg = 13'd240;
      scroll_req_x = 0;
      scroll_req_y = 0;
      tile_col0 = 0;
      tile_row0 = 0;
      rem_x = 0;
      rem_y = 0;
      win_cols = 0;
      win_rows = 0;
      cur_col = 0;
      cur_row = 0;
      frame_open = 1'b0;
      errors = 0;
      items_sent = 0;
      no_idle = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_idle_and_small_frame();
      test_size_extremes();
      test_random_frames();
      wait_drained();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // result side: random hold-off after each accepted word
   initial begin : rsp_pacer
      int hold;
      forever begin
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         hold = no_idle ? 0 : $urandom_range(0, 13);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      draw_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_draws.size() == 0) begin
            $error("unexpected draw word: tile_number %0d", rsp_tile_number);
            errors++;
         end else begin
            want = pending_draws.pop_front();
            if (rsp_tile_number !== want.tile_number) begin
               $error("tile_number: expected %0d, actual %0d", want.tile_number, rsp_tile_number);
               errors++;
            end
            if (rsp_screen_x !== want.screen_x) begin
               $error("screen_x: expected %0d, actual %0d", $signed(want.screen_x), rsp_screen_x);
               errors++;
            end
            if (rsp_screen_y !== want.screen_y) begin
               $error("screen_y: expected %0d, actual %0d", $signed(want.screen_y), rsp_screen_y);
               errors++;
            end
            if (rsp_draw !== want.draw) begin
               $error("draw: expected %0d, actual %0d", want.draw, rsp_draw);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // covers the clearing sweep after reset and the longest frame start
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

endmodule
